// File: hw/rtl/ebt_pkg.sv
`timescale 1ns / 1ps

package ebt_pkg;

    // Coordinate width of the raster counters and box limits
    localparam int COORD_BITS = 12;
    localparam int SUM_BITS   = COORD_BITS + 1;
    localparam int WS_BITS    = 8;
    localparam int CFG_BITS   = (COORD_BITS > WS_BITS) ? COORD_BITS : WS_BITS;
    localparam int CMP_BITS   = ((SUM_BITS > WS_BITS) ? SUM_BITS : WS_BITS) + 1;

    // Stream widths
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_BITS       = 4 * COORD_BITS + 3;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_FRAME_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_FRAME_ROWS    = 2'd1;
    localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd2;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SUM_BITS-1:0]   sum_t;
    typedef logic [WS_BITS-1:0]    wsize_t;

    localparam coord_t RST_FRAME_COLUMNS = COORD_BITS'(640);
    localparam coord_t RST_FRAME_ROWS    = COORD_BITS'(480);
    localparam wsize_t RST_WINDOW_SIZE   = WS_BITS'(30);

    // Search window: start inclusive, end exclusive (last line dropped by the compare)
    typedef struct packed {
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } win_t;

    localparam win_t RST_WIN = '{
        x_start: '0,
        y_start: '0,
        x_end:   RST_FRAME_COLUMNS,
        y_end:   RST_FRAME_ROWS
    };

    typedef struct packed {
        coord_t least_x;
        coord_t greatest_x;
        coord_t least_y;
        coord_t greatest_y;
        logic   seen;
    } box_t;

    localparam box_t BOX_CLEAR = '{
        least_x:    '1,
        greatest_x: '0,
        least_y:    '1,
        greatest_y: '0,
        seen:       1'b0
    };

    // Outcome of the previous frame, used to place the next window
    typedef struct packed {
        coord_t height;
        sum_t   sum_x;
        sum_t   sum_y;
    } hist_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic   box_found;
        sum_t   center_y_doubled;
        sum_t   center_x_doubled;
        coord_t box_height;
        coord_t box_width;
    } result_t;

endpackage

// File: hw/rtl/ebt_win.sv
`timescale 1ns / 1ps

module ebt_win (
    input  ebt_pkg::hist_t  hist,
    input  ebt_pkg::coord_t frame_columns,
    input  ebt_pkg::coord_t frame_rows,
    input  ebt_pkg::wsize_t window_size,
    output ebt_pkg::win_t   win
);
    import ebt_pkg::*;

    function automatic coord_t win_start(sum_t s, wsize_t span);
        logic [CMP_BITS-1:0] se;
        logic [CMP_BITS-1:0] sp;
        logic [CMP_BITS-1:0] d;
        se = CMP_BITS'(s);
        sp = CMP_BITS'(span);
        d  = se - sp + CMP_BITS'(1);
        return (se < sp) ? '0 : COORD_BITS'(d >> 1);
    endfunction

    function automatic coord_t win_end(sum_t s, wsize_t span, coord_t limit);
        logic [CMP_BITS-1:0] e;
        e = (CMP_BITS'(s) + CMP_BITS'(span) + CMP_BITS'(1)) >> 1;
        return (e < CMP_BITS'(limit)) ? COORD_BITS'(e) : limit;
    endfunction

    wsize_t span;
    logic   windowed;

    assign span = {window_size[WS_BITS-1:1], 1'b0};

    // Track only while the last box had non-zero height and was shorter than size-2
    assign windowed = (hist.height != '0) &&
                      (CMP_BITS'(hist.height) + CMP_BITS'(2) < CMP_BITS'(window_size));

    always_comb begin
        if (windowed) begin
            win.x_start = win_start(hist.sum_x, span);
            win.y_start = win_start(hist.sum_y, span);
            win.x_end   = win_end(hist.sum_x, span, frame_columns);
            win.y_end   = win_end(hist.sum_y, span, frame_rows);
        end else begin
            win.x_start = '0;
            win.y_start = '0;
            win.x_end   = frame_columns;
            win.y_end   = frame_rows;
        end
    end

endmodule

// File: hw/rtl/ebt_trk.sv
`timescale 1ns / 1ps

module ebt_trk (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             edge_pixel,
    input  logic             start_of_frame,
    input  ebt_pkg::coord_t  frame_columns,
    input  ebt_pkg::coord_t  frame_rows,
    input  ebt_pkg::win_t    fresh_win,
    output logic             frame_end,
    output ebt_pkg::result_t result,
    output ebt_pkg::hist_t   hist
);
    import ebt_pkg::*;

    coord_t col_reg, col_next;
    coord_t row_reg, row_next;
    box_t   box_reg, box_next;
    win_t   win_reg;
    hist_t  hist_reg;

    coord_t x, y;
    box_t   box_cur, box_upd;
    win_t   win;
    logic   first_pixel, in_window, row_end;
    sum_t   x_inc, y_inc;

    assign x           = start_of_frame ? '0 : col_reg;
    assign y           = start_of_frame ? '0 : row_reg;
    assign box_cur     = start_of_frame ? BOX_CLEAR : box_reg;
    assign first_pixel = (x == '0) && (y == '0);
    assign win         = first_pixel ? fresh_win : win_reg;
    assign x_inc       = SUM_BITS'(x) + SUM_BITS'(1);
    assign y_inc       = SUM_BITS'(y) + SUM_BITS'(1);

    assign in_window = edge_pixel &&
                       (x >= win.x_start) && (x_inc < SUM_BITS'(win.x_end)) &&
                       (y >= win.y_start) && (y_inc < SUM_BITS'(win.y_end));

    always_comb begin
        box_upd = box_cur;
        if (in_window) begin
            if (x < box_cur.least_x)    box_upd.least_x    = x;
            if (x > box_cur.greatest_x) box_upd.greatest_x = x;
            if (y < box_cur.least_y)    box_upd.least_y    = y;
            if (y > box_cur.greatest_y) box_upd.greatest_y = y;
            box_upd.seen = 1'b1;
        end
    end

    assign row_end   = x_inc >= SUM_BITS'(frame_columns);
    assign frame_end = row_end && (y_inc >= SUM_BITS'(frame_rows));

    always_comb begin
        result = '0;
        if (box_upd.seen) begin
            result.box_width        = box_upd.greatest_x - box_upd.least_x;
            result.box_height       = box_upd.greatest_y - box_upd.least_y;
            result.center_x_doubled = SUM_BITS'(box_upd.least_x) + SUM_BITS'(box_upd.greatest_x);
            result.center_y_doubled = SUM_BITS'(box_upd.least_y) + SUM_BITS'(box_upd.greatest_y);
            result.box_found        = 1'b1;
        end
    end

    always_comb begin
        col_next = x + COORD_BITS'(1);
        row_next = y;
        box_next = box_upd;
        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : COORD_BITS'(y_inc);
        end
        if (frame_end) begin
            box_next = BOX_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            box_reg  <= BOX_CLEAR;
            win_reg  <= RST_WIN;
            hist_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
            box_reg <= box_next;
            if (first_pixel) begin
                win_reg <= win;
            end
            if (frame_end) begin
                hist_reg.height <= result.box_height;
                hist_reg.sum_x  <= result.center_x_doubled;
                hist_reg.sum_y  <= result.center_y_doubled;
            end
        end
    end

    assign hist = hist_reg;

endmodule

// File: hw/rtl/edge_bounding_box_tracker_top.sv
`timescale 1ns / 1ps

// Channel   | Direction | tdata (low bit up)                         | tuser
// ----------+-----------+--------------------------------------------+----------------
// s_        | in        | edge_pixel, zero pad to 8 bits             | start_of_frame
// m_        | out       | box_width, box_height, center_x_doubled,   | none
//           |           | center_y_doubled, box_found, zero pad      |
// cfg_      | in        | index 0 frame_columns, 1 frame_rows, 2 window_size
//
// One pixel per clock sustained while no frame-end pixel is stalled: a pixel is
// held in the input register, then the tracker updates counters, window and box
// and, on the last pixel of a frame, loads the result register.
// Only a frame-end pixel waits on a full result register; other pixels flow on.
// Synchronous active-low reset clears counters, box, history and both valids.
module edge_bounding_box_tracker_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Pixel stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ebt_pkg::IN_TDATA_BITS-1:0]    s_tdata,  // edge_pixel, pad
    input  logic                                 s_tuser,  // start_of_frame
    // Box results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ebt_pkg::OUT_TDATA_BITS-1:0]   m_tdata,  // width, height, cx2, cy2,
                                                           // found, pad
    // Configuration writes
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_addr,
    input  logic [ebt_pkg::CFG_BITS-1:0]         cfg_wdata
);
    import ebt_pkg::*;

    // Configuration registers
    coord_t frame_columns_reg;
    coord_t frame_rows_reg;
    wsize_t window_size_reg;

    // Input register
    logic in_vld_reg, in_vld_next;
    logic in_edge_reg;
    logic in_sof_reg;

    // Result register
    logic    out_vld_reg, out_vld_next;
    result_t out_data_reg;

    // Tracker interface
    logic    advance;
    logic    frame_end;
    result_t result;
    hist_t   hist;
    win_t    fresh_win;
    logic    out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_columns_reg <= RST_FRAME_COLUMNS;
            frame_rows_reg    <= RST_FRAME_ROWS;
            window_size_reg   <= RST_WINDOW_SIZE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_FRAME_COLUMNS: frame_columns_reg <= COORD_BITS'(cfg_wdata);
                CFG_FRAME_ROWS:    frame_rows_reg    <= COORD_BITS'(cfg_wdata);
                CFG_WINDOW_SIZE:   window_size_reg   <= WS_BITS'(cfg_wdata);
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Advance a pixel unless it closes a frame and the result slot is blocked
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && (!frame_end || out_free);
    assign s_tready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance && frame_end) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload: hold while stalled, load on each accepted transaction
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_edge_reg <= s_tdata[0];
            in_sof_reg  <= s_tuser;
        end
        if (advance && frame_end) begin
            out_data_reg <= result;
        end
    end

    // Window for the next frame, from the last frame's box and the registers
    ebt_win u_win (
        .hist          (hist),
        .frame_columns (frame_columns_reg),
        .frame_rows    (frame_rows_reg),
        .window_size   (window_size_reg),
        .win           (fresh_win)
    );

    ebt_trk u_trk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .edge_pixel     (in_edge_reg),
        .start_of_frame (in_sof_reg),
        .frame_columns  (frame_columns_reg),
        .frame_rows     (frame_rows_reg),
        .fresh_win      (fresh_win),
        .frame_end      (frame_end),
        .result         (result),
        .hist           (hist)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS - OUT_BITS){1'b0}}, out_data_reg};

endmodule

// File: hw/rtl/ebt_checker.sv
`timescale 1ns / 1ps

module ebt_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ebt_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
    import ebt_pkg::*;

    localparam int W_LO  = 0;
    localparam int H_LO  = COORD_BITS;
    localparam int CX_LO = 2 * COORD_BITS;
    localparam int CY_LO = 3 * COORD_BITS + 1;
    localparam int F_BIT = 4 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] w_f, h_f;
    logic [SUM_BITS-1:0]   cx_f, cy_f;
    logic                  found_f;

    assign w_f     = m_tdata[W_LO +: COORD_BITS];
    assign h_f     = m_tdata[H_LO +: COORD_BITS];
    assign cx_f    = m_tdata[CX_LO +: SUM_BITS];
    assign cy_f    = m_tdata[CY_LO +: SUM_BITS];
    assign found_f = m_tdata[F_BIT];

    // Result register is empty the cycle after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // An empty frame reports all zeros
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !found_f |-> (w_f == '0) && (h_f == '0) && (cx_f == '0) && (cy_f == '0))
        else $error("empty box with non-zero fields");

    // Size never exceeds the doubled centre (least plus greatest)
    a_size_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && found_f |-> (SUM_BITS'(w_f) <= cx_f) && (SUM_BITS'(h_f) <= cy_f))
        else $error("box size above doubled centre");

endmodule

bind edge_bounding_box_tracker_top ebt_checker u_ebt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
